@@ rtl/svm_pkg.sv @@
// supply voltage monitor package: register map, reset values, payload and
// control structs shared by all rtl files; depends on nothing
package svm_pkg;

  localparam int ADC_W     = 10;
  localparam int MV_W      = 16;
  localparam int SCALE_W   = 21;
  localparam int GRACE_W   = 8;
  localparam int STEP_W    = 8;
  localparam int DIV_W     = SCALE_W;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [MV_W-1:0] MV_MAX = '1;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_VOLT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REF_SCALE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRACE_LEN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TICK_STEP = 3'd5;

  localparam logic [MV_W-1:0]    RST_HIGH_THR  = 16'd4000;
  localparam logic [MV_W-1:0]    RST_LOW_THR   = 16'd3000;
  localparam logic [MV_W-1:0]    RST_LOW_VOLT  = 16'd3300;
  localparam logic [SCALE_W-1:0] RST_REF_SCALE = 21'd1125300;
  localparam logic [GRACE_W-1:0] RST_GRACE_LEN = 8'd2;
  localparam logic [STEP_W-1:0]  RST_TICK_STEP = 8'd100;

  typedef struct packed {
    logic             mode;
    logic [ADC_W-1:0] adc_sample;
  } svm_in_t;

  typedef struct packed {
    logic [MV_W-1:0] vcc_mv;
    logic            adc_stable;
    logic            power_connected;
    logic            power_lost;
    logic            power_low;
  } svm_out_t;

  typedef struct packed {
    logic [MV_W-1:0]    high_thr;
    logic [MV_W-1:0]    low_thr;
    logic [MV_W-1:0]    low_volt;
    logic [SCALE_W-1:0] ref_scale;
    logic [GRACE_W-1:0] grace_len;
    logic [STEP_W-1:0]  tick_step;
  } svm_cfg_t;

  typedef struct packed {
    logic update;
    logic div_start;
    logic load_avg;
    logic load_out;
  } svm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } svm_sts_t;

endpackage

@@ rtl/svm_div.sv @@
// supply voltage monitor divider: restoring unsigned divider, one quotient
// bit per cycle; depends on svm_pkg
module svm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [svm_pkg::DIV_W-1:0] num,
  input  logic [svm_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [svm_pkg::DIV_W-1:0] quo
);

  localparam int W     = svm_pkg::DIV_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     q_r, rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       shifted;
  logic             ge;
  logic [W-1:0]     rem_nxt;

  always_comb begin
    shifted = {rem_r, q_r[W-1]};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? W'(shifted - {1'b0, den_r}) : W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/svm_dpath.sv @@
// supply voltage monitor datapath: sample ring with running sum, tick and
// grace counters, ring average, divider, flag logic and output register;
// depends on svm_pkg, svm_div
module svm_dpath #(
  parameter int RING_DEPTH    = 5,
  parameter int STABLE_TARGET = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  svm_pkg::svm_cfg_t cfg,
  input  svm_pkg::svm_in_t  in_data,
  input  svm_pkg::svm_cmd_t cmd,
  output svm_pkg::svm_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output svm_pkg::svm_out_t out_data
);

  localparam int SAMPLE_BITS = svm_pkg::ADC_W;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int STABLE_W    = $clog2(STABLE_TARGET + 1);
  localparam int W           = svm_pkg::DIV_W;
  localparam int MV_W        = svm_pkg::MV_W;
  // average by reciprocal multiplication, exact for every ring sum
  localparam int AVG_SH      = SUM_W + $clog2(RING_DEPTH);
  localparam int PROD_W      = SUM_W + AVG_SH;
  localparam logic [PROD_W-1:0] AVG_MUL = PROD_W'(((64'd1 << AVG_SH) + 64'(RING_DEPTH)
                                                   - 64'd1) / 64'(RING_DEPTH));

  logic [SAMPLE_BITS-1:0]      ring_r [RING_DEPTH];
  logic [SLOT_W-1:0]           slot_r;
  logic [SUM_W-1:0]            sum_r;
  logic [STABLE_W-1:0]         stable_r;
  logic [svm_pkg::STEP_W-1:0]  tick_r;
  logic [svm_pkg::GRACE_W-1:0] grace_r;
  logic [SAMPLE_BITS-1:0]      avg_r;
  logic                        out_valid_r;
  svm_pkg::svm_out_t           out_data_r;

  logic [SAMPLE_BITS-1:0]     sample;
  logic [svm_pkg::STEP_W-1:0] tick_inc;
  logic [PROD_W-1:0]          avg_prod;
  logic [W-1:0]               div_num, div_den, quo;
  logic                       div_done;
  logic [MV_W-1:0]            vcc;
  logic                       grace_on;
  svm_pkg::svm_out_t          result;

  assign sample   = SAMPLE_BITS'(in_data.adc_sample);
  assign tick_inc = tick_r + svm_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
      slot_r   <= '0;
      sum_r    <= '0;
      stable_r <= '0;
      tick_r   <= '0;
      grace_r  <= '0;
    end else if (cmd.update) begin
      if (!in_data.mode) begin
        ring_r[slot_r] <= sample;
        sum_r <= sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(sample);
        slot_r <= (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (stable_r != STABLE_W'(STABLE_TARGET)) stable_r <= stable_r + STABLE_W'(1);
        // grace steps down once the tick count passes the step length
        if (tick_inc > cfg.tick_step) begin
          tick_r <= '0;
          if (grace_r != '0) grace_r <= grace_r - svm_pkg::GRACE_W'(1);
        end else begin
          tick_r <= tick_inc;
        end
      end else begin
        grace_r <= cfg.grace_len;
      end
    end
  end

  assign avg_prod = PROD_W'(sum_r) * AVG_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load_avg) avg_r <= avg_prod[AVG_SH +: SAMPLE_BITS];
  end

  assign div_num = cfg.ref_scale;
  assign div_den = W'(avg_r);

  svm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    if (avg_r == '0 || quo[W-1:MV_W] != '0) vcc = svm_pkg::MV_MAX;
    else vcc = quo[MV_W-1:0];
    grace_on               = grace_r != '0;
    result.vcc_mv          = vcc;
    result.adc_stable      = stable_r == STABLE_W'(STABLE_TARGET);
    result.power_connected = grace_on || (vcc > cfg.high_thr);
    result.power_lost      = !grace_on && (vcc < cfg.low_thr);
    result.power_low       = !grace_on && (vcc < cfg.low_volt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= result;
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(RING_DEPTH - 1))
    else $error("ring slot out of range");

  a_stable_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r <= STABLE_W'(STABLE_TARGET))
    else $error("stable count past target");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_div_multi: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !div_done)
    else $error("divider finished in one cycle");

endmodule

@@ rtl/svm_ctrl.sv @@
// supply voltage monitor controller: sequences state update, the ring
// average, the divider pass and the result transfer; depends on svm_pkg
module svm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output svm_pkg::svm_cmd_t cmd,
  input  svm_pkg::svm_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_MV_GO,
    S_MV_RUN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.update = 1'b1;
          state_nxt  = S_AVG;
        end
      end
      S_AVG: begin
        cmd.load_avg = 1'b1;
        state_nxt    = S_MV_GO;
      end
      S_MV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MV_RUN;
      end
      S_MV_RUN: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here only while the previous result is still unread
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an unread one");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.load_avg ##1 cmd.div_start)
    else $error("accepted item did not start the divider");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.update, cmd.div_start, cmd.load_avg, cmd.load_out}))
    else $error("overlapping controller commands");

endmodule

@@ rtl/supply_voltage_monitor.sv @@
// supply voltage monitor top level: configuration registers behind the
// register port, controller and datapath; depends on svm_pkg, svm_ctrl, svm_dpath
//
// usage:
//  - in channel (in_valid/in_ready/in_data): one item per 10 ms tick; mode 0
//    carries a reference sample, mode 1 loads the grace countdown
//  - out channel (out_valid/out_ready/out_data): exactly one result per item,
//    supply millivolts plus stable, connected, lost and low flags
//  - register port (psel/penable/pwrite/paddr/pwdata/prdata/pready): six
//    registers at byte addresses 0x00..0x14, pready is tied high, write only
//    while no item is in flight
//  - after the input transfer: update, ring average register, divider start,
//    the bit-serial divider (scale over average), done, output load
//  - in_ready is high only while no item is in flight; a finished result sits
//    in the output register, so the next item is taken while it waits
//  - if the receiver stalls, the following result is held back until the
//    earlier one is transferred, and in_ready stays low meanwhile
//  - reset clears the ring, counters and grace countdown and restores the
//    register defaults; no clearing pass is needed
module supply_voltage_monitor #(
  parameter int RING_DEPTH    = 5,
  parameter int STABLE_TARGET = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  svm_pkg::svm_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output svm_pkg::svm_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svm_pkg::PADDR_W-1:0] paddr,
  input  logic [svm_pkg::PDATA_W-1:0] pwdata,
  output logic [svm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int DW = svm_pkg::PDATA_W;

  svm_pkg::svm_cfg_t cfg_r;
  svm_pkg::svm_cmd_t cmd;
  svm_pkg::svm_sts_t sts;
  logic [svm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[svm_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_thr  <= svm_pkg::RST_HIGH_THR;
      cfg_r.low_thr   <= svm_pkg::RST_LOW_THR;
      cfg_r.low_volt  <= svm_pkg::RST_LOW_VOLT;
      cfg_r.ref_scale <= svm_pkg::RST_REF_SCALE;
      cfg_r.grace_len <= svm_pkg::RST_GRACE_LEN;
      cfg_r.tick_step <= svm_pkg::RST_TICK_STEP;
    end else if (wr_en) begin
      case (reg_idx)
        svm_pkg::REG_HIGH_THR:  cfg_r.high_thr  <= pwdata[svm_pkg::MV_W-1:0];
        svm_pkg::REG_LOW_THR:   cfg_r.low_thr   <= pwdata[svm_pkg::MV_W-1:0];
        svm_pkg::REG_LOW_VOLT:  cfg_r.low_volt  <= pwdata[svm_pkg::MV_W-1:0];
        svm_pkg::REG_REF_SCALE: cfg_r.ref_scale <= pwdata[svm_pkg::SCALE_W-1:0];
        svm_pkg::REG_GRACE_LEN: cfg_r.grace_len <= pwdata[svm_pkg::GRACE_W-1:0];
        svm_pkg::REG_TICK_STEP: cfg_r.tick_step <= pwdata[svm_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      svm_pkg::REG_HIGH_THR:  prdata = DW'(cfg_r.high_thr);
      svm_pkg::REG_LOW_THR:   prdata = DW'(cfg_r.low_thr);
      svm_pkg::REG_LOW_VOLT:  prdata = DW'(cfg_r.low_volt);
      svm_pkg::REG_REF_SCALE: prdata = DW'(cfg_r.ref_scale);
      svm_pkg::REG_GRACE_LEN: prdata = DW'(cfg_r.grace_len);
      svm_pkg::REG_TICK_STEP: prdata = DW'(cfg_r.tick_step);
      default:                prdata = '0;
    endcase
  end

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  svm_dpath #(
    .RING_DEPTH    (RING_DEPTH),
    .STABLE_TARGET (STABLE_TARGET)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/supply_voltage_monitor_tb.sv @@
// testbench for supply_voltage_monitor: directed and randomized ticks and grace
// items checked against a cycle-free predictor of the ring average, divider and
// flags; depends on svm_pkg and the supply_voltage_monitor rtl
module supply_voltage_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH    = 5;
  localparam int STABLE_TARGET = 10;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  svm_pkg::svm_in_t             in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  svm_pkg::svm_out_t            out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [svm_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [svm_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [svm_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // predictor state, reset values
  svm_pkg::svm_cfg_t settings = '{high_thr: svm_pkg::RST_HIGH_THR,
                                  low_thr: svm_pkg::RST_LOW_THR,
                                  low_volt: svm_pkg::RST_LOW_VOLT,
                                  ref_scale: svm_pkg::RST_REF_SCALE,
                                  grace_len: svm_pkg::RST_GRACE_LEN,
                                  tick_step: svm_pkg::RST_TICK_STEP};
  logic [svm_pkg::ADC_W-1:0]    sample_ring [RING_DEPTH];
  int unsigned                  ring_slot  = 0;
  logic [3:0]                   stable_cnt = '0;
  logic [7:0]                   tick_cnt   = '0;
  logic [svm_pkg::GRACE_W-1:0]  grace_cnt  = '0;

  svm_pkg::svm_in_t             pending_items [$];
  svm_pkg::svm_out_t            expected_readings [$];
  svm_pkg::svm_out_t            want;
  int unsigned                  items_taken    = 0;
  int unsigned                  errors         = 0;
  int unsigned                  send_idle_pct  = 0;
  int unsigned                  recv_idle_pct  = 0;
  int unsigned                  hold_after     = 32'hFFFF_FFFF;
  logic                         rx_hold        = 1'b0;

  supply_voltage_monitor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) sample_ring[i] = '0;
  end

  // advance the monitor state by one item and return the reading it reports
  function automatic svm_pkg::svm_out_t supply_step(svm_pkg::svm_in_t item);
    logic [12:0]                 ring_sum;
    logic [10:0]                 ring_avg;
    logic [svm_pkg::SCALE_W-1:0] quot;
    logic [svm_pkg::MV_W-1:0]    mv;
    logic                        grace_on;
    svm_pkg::svm_out_t           res;
    if (item.mode == 1'b0) begin
      if (stable_cnt < STABLE_TARGET) stable_cnt = stable_cnt + 1'b1;
      sample_ring[ring_slot] = item.adc_sample;
      ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt > settings.tick_step) begin
        tick_cnt = '0;
        if (grace_cnt != 0) grace_cnt = grace_cnt - 1'b1;
      end
    end else begin
      grace_cnt = settings.grace_len;
    end
    ring_sum = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_sum = ring_sum + sample_ring[i];
    ring_avg = 11'(ring_sum / RING_DEPTH);
    if (ring_avg == 0) begin
      mv = svm_pkg::MV_MAX;
    end else begin
      quot = settings.ref_scale / ring_avg;
      mv = (quot > svm_pkg::MV_MAX) ? svm_pkg::MV_MAX : quot[svm_pkg::MV_W-1:0];
    end
    grace_on = (grace_cnt != 0);
    res.vcc_mv          = mv;
    res.adc_stable      = (stable_cnt >= STABLE_TARGET);
    res.power_connected = grace_on || (mv > settings.high_thr);
    res.power_lost      = !grace_on && (mv < settings.low_thr);
    res.power_low       = !grace_on && (mv < settings.low_volt);
    return res;
  endfunction

  // input driver: new item only when the slot is free, random idle cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(supply_step(in_data));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
               exp_val, got_val);
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected transfer, expected none, actual %h", $time,
                   out_data);
        end else begin
          want = expected_readings.pop_front();
          check_field("vcc_mv", 32'(want.vcc_mv), 32'(out_data.vcc_mv));
          check_field("adc_stable", 32'(want.adc_stable), 32'(out_data.adc_stable));
          check_field("power_connected", 32'(want.power_connected),
                      32'(out_data.power_connected));
          check_field("power_lost", 32'(want.power_lost), 32'(out_data.power_lost));
          check_field("power_low", 32'(want.power_low), 32'(out_data.power_low));
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // long receiver stall so the output register fills and in_ready drops
  initial begin
    wait (rst_n && items_taken >= hold_after);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (500) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #15_000_000;
    $display("** supply_voltage_monitor: FAILED **");
    $finish;
  end

  task automatic reg_write(input logic [svm_pkg::REG_IDX_W-1:0] idx,
                           input logic [svm_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      svm_pkg::REG_HIGH_THR:  settings.high_thr  = value[svm_pkg::MV_W-1:0];
      svm_pkg::REG_LOW_THR:   settings.low_thr   = value[svm_pkg::MV_W-1:0];
      svm_pkg::REG_LOW_VOLT:  settings.low_volt  = value[svm_pkg::MV_W-1:0];
      svm_pkg::REG_REF_SCALE: settings.ref_scale = value[svm_pkg::SCALE_W-1:0];
      svm_pkg::REG_GRACE_LEN: settings.grace_len = value[svm_pkg::GRACE_W-1:0];
      svm_pkg::REG_TICK_STEP: settings.tick_step = value[svm_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned high_mv, input int unsigned low_mv,
                                input int unsigned lowv_mv, input int unsigned scale,
                                input int unsigned glen, input int unsigned step);
    reg_write(svm_pkg::REG_HIGH_THR, high_mv);
    reg_write(svm_pkg::REG_LOW_THR, low_mv);
    reg_write(svm_pkg::REG_LOW_VOLT, lowv_mv);
    reg_write(svm_pkg::REG_REF_SCALE, scale);
    reg_write(svm_pkg::REG_GRACE_LEN, glen);
    reg_write(svm_pkg::REG_TICK_STEP, step);
  endtask

  task automatic add_item(input logic mode, input int unsigned sample);
    svm_pkg::svm_in_t item;
    item.mode       = mode;
    item.adc_sample = sample[svm_pkg::ADC_W-1:0];
    pending_items.push_back(item);
  endtask

  // sender waits here until every reading has come back
  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random items: samples biased toward the threshold region and tiny averages
  task automatic random_phase(input int unsigned count, input int unsigned grace_pct,
                              input int unsigned s_pct, input int unsigned r_pct);
    int unsigned pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    @(negedge clk);
    repeat (count) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < grace_pct) add_item(1'b1, $urandom_range(1023));
      else if (pick < 55) add_item(1'b0, $urandom_range(250, 420));
      else if (pick < 85) add_item(1'b0, $urandom_range(1023));
      else add_item(1'b0, $urandom_range(20));
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: zero average, big readings, grace, tiny averages
    @(negedge clk);
    add_item(1'b0, 0);
    add_item(1'b0, 1023);
    add_item(1'b0, 1023);
    add_item(1'b1, 1023);
    add_item(1'b0, 1023);
    add_item(1'b0, 1023);
    add_item(1'b0, 0);
    repeat (5) add_item(1'b0, 10);
    repeat (5) add_item(1'b0, 18);
    drain();

    // directed, extremes: zero scale, zero step, longest grace
    apply_settings(65535, 0, 0, 0, 255, 0);
    @(negedge clk);
    add_item(1'b1, 0);
    add_item(1'b0, 1023);
    add_item(1'b0, 1023);
    repeat (5) add_item(1'b0, 0);
    drain();

    apply_settings(4000, 3000, 3300, 1125300, 4, 3);
    random_phase(700, 8, 32, 46);

    // opposite extremes, step 255 so the tick counter wraps without grace drops
    apply_settings(0, 65535, 65535, 2097151, 0, 255);
    random_phase(500, 5, 46, 32);

    apply_settings($urandom_range(2000, 8000), $urandom_range(1000, 4000),
                   $urandom_range(1000, 5000), $urandom_range(200000, 2097151),
                   $urandom_range(12), $urandom_range(7));
    hold_after = items_taken + 150;
    random_phase(700, 10, 0, 0);

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** supply_voltage_monitor: PASSED **");
    end else begin
      $display("** supply_voltage_monitor: FAILED **");
    end
    $finish;
  end

endmodule
